// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the sequencer top level.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// ===== hw/rtl/ncs_pkg.sv =====
// Types, codes and bus constants of the NAND flash command sequencer.
// No dependencies.
`timescale 1ns / 1ps
package ncs_pkg;

	localparam int PAGE_BYTES_DEF = 512;

	localparam logic [2:0] OPC_PROG  = 3'd0;
	localparam logic [2:0] OPC_READ  = 3'd1;
	localparam logic [2:0] OPC_ERASE = 3'd2;
	localparam logic [2:0] OPC_ID    = 3'd3;
	localparam logic [2:0] OPC_STEP  = 3'd4;

	localparam logic [7:0] CMD_PROG     = 8'h80;
	localparam logic [7:0] CMD_PROG_GO  = 8'h10;
	localparam logic [7:0] CMD_READ     = 8'h00;
	localparam logic [7:0] CMD_ERASE    = 8'h60;
	localparam logic [7:0] CMD_ERASE_GO = 8'hD0;
	localparam logic [7:0] CMD_STATUS   = 8'h70;
	localparam logic [7:0] CMD_ID       = 8'h90;
	localparam logic [7:0] BYTE_PAD     = 8'hFF;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;

	localparam logic [2:0] K_IDLE  = 3'd0;
	localparam logic [2:0] K_CMD   = 3'd1;
	localparam logic [2:0] K_ADDR  = 3'd2;
	localparam logic [2:0] K_WRITE = 3'd3;
	localparam logic [2:0] K_READ  = 3'd4;
	localparam logic [2:0] K_WAIT  = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD,
		PH_ADDR,
		PH_DATA,
		PH_FINAL,
		PH_WAIT,
		PH_STATUS
	} phase_t;

	typedef enum logic [1:0] {
		OP_PROG,
		OP_READ,
		OP_ERASE,
		OP_ID
	} oper_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] page;
		logic [9:0]  data_length;
		logic [7:0]  write_data;
		logic [7:0]  bus_data;
		logic        ready_req;
	} in_item_t;

	typedef struct packed {
		logic [2:0] cycle_kind;
		logic [7:0] bus_byte;
		logic       done_res;
		logic       erase_error;
	} out_item_t;

endpackage

// ===== hw/rtl/ncs_stream_if.sv =====
// Valid/ready channel carrying one word of a packed payload type.
// Payload types come from ncs_pkg.
`timescale 1ns / 1ps
interface ncs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ncs_in_stage.sv =====
// Input register of the sequencer: holds one accepted command word.
// Depends on ncs_pkg and ncs_stream_if.
`timescale 1ns / 1ps
module ncs_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	ncs_stream_if.sink       cmd,
	input  logic             advance,
	output logic             valid_s1,
	output ncs_pkg::in_item_t item_s1
);
	import ncs_pkg::*;

	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.data;
		end
	end
endmodule

// ===== hw/rtl/ncs_seq.sv =====
// Sequencer state and bus cycle decode for one command word.
// Depends on ncs_pkg.
`timescale 1ns / 1ps
module ncs_seq #(
	parameter int PAGE_BYTES = ncs_pkg::PAGE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  ncs_pkg::in_item_t  item,
	output ncs_pkg::out_item_t result
);
	import ncs_pkg::*;

	localparam int CNT_W = $clog2(PAGE_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_PAGE = CNT_W'(PAGE_BYTES);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_FOUR = CNT_W'(4);

	phase_t            phase_q, phase_d;
	oper_t             oper_q, oper_d;
	logic [15:0]       page_q, page_d;
	logic [CNT_W-1:0]  len_q, len_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  naddr;
	logic              len_over;

	assign cnt_inc  = cnt_q + CNT_ONE;
	assign len_over = 32'(item.data_length) > 32'(PAGE_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			oper_q  <= OP_PROG;
			page_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			oper_q  <= oper_d;
			page_q  <= page_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		oper_d  = oper_q;
		page_d  = page_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		result  = '{cycle_kind: K_IDLE, bus_byte: BYTE_ZERO, done_res: 1'b0,
			erase_error: 1'b0};
		naddr   = CNT_FOUR;
		if (item.opcode == OPC_PROG || item.opcode == OPC_READ ||
				item.opcode == OPC_ERASE || item.opcode == OPC_ID) begin
			oper_d  = oper_t'(item.opcode[1:0]);
			page_d  = item.page;
			len_d   = len_over ? CNT_PAGE : CNT_W'(item.data_length);
			cnt_d   = '0;
			phase_d = PH_CMD;
		end else if (item.opcode == OPC_STEP) begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_CMD: begin
					result.cycle_kind = K_CMD;
					unique case (oper_q)
						OP_PROG:  result.bus_byte = CMD_PROG;
						OP_READ:  result.bus_byte = CMD_READ;
						OP_ERASE: result.bus_byte = CMD_ERASE;
						OP_ID:    result.bus_byte = CMD_ID;
						default:  result.bus_byte = CMD_ID;
					endcase
					phase_d = PH_ADDR;
					cnt_d   = '0;
				end
				PH_ADDR: begin
					result.cycle_kind = K_ADDR;
					if (oper_q == OP_ERASE) begin
						naddr = CNT_THREE;
						result.bus_byte = (cnt_q == '0) ? page_q[7:0] :
							(cnt_q == CNT_ONE) ? page_q[15:8] : BYTE_ZERO;
					end else if (oper_q == OP_ID) begin
						naddr = CNT_ONE;
						result.bus_byte = BYTE_ZERO;
					end else begin
						naddr = CNT_FOUR;
						result.bus_byte = (cnt_q == CNT_ONE) ? page_q[7:0] :
							(cnt_q == CNT_TWO) ? page_q[15:8] : BYTE_ZERO;
					end
					cnt_d = cnt_inc;
					if (cnt_inc >= naddr) begin
						cnt_d   = '0;
						phase_d = (oper_q == OP_ERASE) ? PH_FINAL : PH_DATA;
					end
				end
				PH_DATA: begin
					cnt_d = cnt_inc;
					if (oper_q == OP_PROG) begin
						result.cycle_kind = K_WRITE;
						result.bus_byte = (cnt_q < len_q) ? item.write_data : BYTE_PAD;
						if (cnt_inc >= CNT_PAGE) begin
							cnt_d   = '0;
							phase_d = PH_FINAL;
						end
					end else begin
						result.cycle_kind = K_READ;
						result.bus_byte   = item.bus_data;
						if (cnt_inc >= ((oper_q == OP_ID) ? CNT_TWO : CNT_PAGE)) begin
							result.done_res = 1'b1;
							cnt_d   = '0;
							phase_d = PH_IDLE;
						end
					end
				end
				PH_FINAL: begin
					result.cycle_kind = K_CMD;
					if (oper_q == OP_ERASE) begin
						result.bus_byte = CMD_ERASE_GO;
						phase_d = PH_WAIT;
					end else begin
						result.bus_byte = CMD_PROG_GO;
						result.done_res = 1'b1;
						cnt_d   = '0;
						phase_d = PH_IDLE;
					end
				end
				PH_WAIT: begin
					if (item.ready_req) begin
						result.cycle_kind = K_CMD;
						result.bus_byte   = CMD_STATUS;
						phase_d = PH_STATUS;
					end else begin
						result.cycle_kind = K_WAIT;
					end
				end
				PH_STATUS: begin
					result.cycle_kind  = K_READ;
					result.bus_byte    = item.bus_data;
					result.done_res    = 1'b1;
					result.erase_error = item.bus_data[0];
					cnt_d   = '0;
					phase_d = PH_IDLE;
				end
				default: begin
					cnt_d   = '0;
					phase_d = PH_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/ncs_out_stage.sv =====
// Result register of the sequencer: holds one bus cycle word until taken.
// Depends on ncs_pkg and ncs_stream_if.
`timescale 1ns / 1ps
module ncs_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  ncs_pkg::out_item_t result,
	output logic               space,
	ncs_stream_if.source       rsp
);
	import ncs_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign space     = !valid_q || rsp.ready;
	assign rsp.valid = valid_q;
	assign rsp.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			data_q <= result;
		end
	end
endmodule

// ===== hw/rtl/nand_flash_command_sequencer.sv =====
// NAND flash command sequencer top level: input register, sequencer, result register.
// Depends on ncs_pkg, ncs_stream_if, ncs_in_stage, ncs_seq, ncs_out_stage.
//
// cmd carries one command word per handshake: a start opcode (program, read,
// erase, read-ID) with page and length, or a step with write data, sampled
// bus data and the ready/busy level. rsp returns exactly one word for each
// command word: the flash bus cycle to run (kind, byte, done, erase error),
// or an idle word for starts, stray steps and unused opcodes.
// An accepted word passes through the input register and then the result register to rsp.
// Throughput: one word per cycle while rsp does not stall; the sequencer state register updates in
// the same cycle a word moves from the input register to the result register.
// Reset clears both valid flags and puts the sequencer idle; no clearing pass.
// When rsp stalls, the result register holds, the input register fills and
// cmd.ready drops; cmd.ready rises again in the cycle rsp takes its word.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nand_flash_command_sequencer #(
	parameter int PAGE_BYTES = ncs_pkg::PAGE_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ncs_stream_if.sink   cmd,
	ncs_stream_if.source rsp
);
	import ncs_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t result;
	logic      space;
	logic      fire;

	assign fire = valid_s1 && space;

	ncs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (space),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ncs_seq #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	ncs_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.result (result),
		.space  (space),
		.rsp    (rsp)
	);

	`ASSERT_CLK(a_done_kind, rsp.valid && rsp.data.done_res |-> rsp.data.cycle_kind == K_CMD || rsp.data.cycle_kind == K_READ)
	`ASSERT_CLK(a_err_with_done, rsp.valid && rsp.data.erase_error |-> rsp.data.done_res)
	`ASSERT_CLK(a_idle_zero, rsp.valid && rsp.data.cycle_kind == K_IDLE |-> rsp.data.bus_byte == BYTE_ZERO && !rsp.data.done_res)
	`ASSERT_NEVER(a_full_stall_ready, rsp.valid && !rsp.ready && valid_s1 && cmd.ready)
endmodule

// ===== dv/ncs_bus_cycle_check.sv =====
// Bus cycle checker for the NAND flash command sequencer: tracks the sequence state
// from accepted command words and compares every result word field by field.
// Depends on ncs_pkg.
`timescale 1ns / 1ps
module ncs_bus_cycle_check
	import ncs_pkg::*;
#(
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  in_item_t  cmd_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  out_item_t rsp_data,
	output int        errors,
	output int        pending
);

	phase_t      phase;
	oper_t       oper;
	logic [15:0] page_q;
	int          length_q;
	int          slot;
	out_item_t   want;
	out_item_t   due_cycles[$];

	function automatic out_item_t bus_cycle(logic [2:0] kind, logic [7:0] b, logic d, logic e);
		out_item_t r;
		r.cycle_kind  = kind;
		r.bus_byte    = b;
		r.done_res    = d;
		r.erase_error = e;
		return r;
	endfunction

	function automatic out_item_t next_bus_cycle(input in_item_t w);
		out_item_t  r;
		int         naddr;
		logic [7:0] b;
		r = '0;
		if (w.opcode <= OPC_ID) begin
			oper     = oper_t'(w.opcode[1:0]);
			page_q   = w.page;
			length_q = (int'(w.data_length) > PAGE_BYTES) ? PAGE_BYTES : int'(w.data_length);
			slot     = 0;
			phase    = PH_CMD;
			return r;
		end
		if (w.opcode != OPC_STEP || phase == PH_IDLE)
			return r;
		case (phase)
			PH_CMD: begin
				case (oper)
					OP_PROG:  r = bus_cycle(K_CMD, CMD_PROG, 1'b0, 1'b0);
					OP_READ:  r = bus_cycle(K_CMD, CMD_READ, 1'b0, 1'b0);
					OP_ERASE: r = bus_cycle(K_CMD, CMD_ERASE, 1'b0, 1'b0);
					default:  r = bus_cycle(K_CMD, CMD_ID, 1'b0, 1'b0);
				endcase
				phase = PH_ADDR;
				slot  = 0;
			end
			PH_ADDR: begin
				if (oper == OP_ERASE) begin
					naddr = 3;
					b = (slot == 0) ? page_q[7:0] : (slot == 1) ? page_q[15:8] : BYTE_ZERO;
				end else if (oper == OP_ID) begin
					naddr = 1;
					b = BYTE_ZERO;
				end else begin
					naddr = 4;
					b = (slot == 1) ? page_q[7:0] : (slot == 2) ? page_q[15:8] : BYTE_ZERO;
				end
				r = bus_cycle(K_ADDR, b, 1'b0, 1'b0);
				slot++;
				if (slot >= naddr) begin
					slot  = 0;
					phase = (oper == OP_ERASE) ? PH_FINAL : PH_DATA;
				end
			end
			PH_DATA: begin
				if (oper == OP_PROG) begin
					r = bus_cycle(K_WRITE, (slot < length_q) ? w.write_data : BYTE_PAD, 1'b0, 1'b0);
					slot++;
					if (slot >= PAGE_BYTES) begin
						slot  = 0;
						phase = PH_FINAL;
					end
				end else begin
					slot++;
					if (slot >= ((oper == OP_ID) ? 2 : PAGE_BYTES)) begin
						r     = bus_cycle(K_READ, w.bus_data, 1'b1, 1'b0);
						phase = PH_IDLE;
						slot  = 0;
					end else begin
						r = bus_cycle(K_READ, w.bus_data, 1'b0, 1'b0);
					end
				end
			end
			PH_FINAL: begin
				if (oper == OP_ERASE) begin
					r     = bus_cycle(K_CMD, CMD_ERASE_GO, 1'b0, 1'b0);
					phase = PH_WAIT;
				end else begin
					r     = bus_cycle(K_CMD, CMD_PROG_GO, 1'b1, 1'b0);
					phase = PH_IDLE;
					slot  = 0;
				end
			end
			PH_WAIT: begin
				if (w.ready_req) begin
					r     = bus_cycle(K_CMD, CMD_STATUS, 1'b0, 1'b0);
					phase = PH_STATUS;
				end else begin
					r = bus_cycle(K_WAIT, BYTE_ZERO, 1'b0, 1'b0);
				end
			end
			PH_STATUS: begin
				r     = bus_cycle(K_READ, w.bus_data, 1'b1, w.bus_data[0]);
				phase = PH_IDLE;
				slot  = 0;
			end
			default: begin
				phase = PH_IDLE;
				slot  = 0;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_cycles.delete();
			phase    = PH_IDLE;
			oper     = OP_PROG;
			page_q   = '0;
			length_q = 0;
			slot     = 0;
			errors   = 0;
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_cycles.size() == 0) begin
					$error("result word with no command word pending");
					errors++;
				end else begin
					want = due_cycles.pop_front();
					if (rsp_data.cycle_kind !== want.cycle_kind) begin
						$error("cycle_kind: expected %0d, got %0d", want.cycle_kind,
							rsp_data.cycle_kind);
						errors++;
					end
					if (rsp_data.bus_byte !== want.bus_byte) begin
						$error("bus_byte: expected %0h, got %0h", want.bus_byte, rsp_data.bus_byte);
						errors++;
					end
					if (rsp_data.done_res !== want.done_res) begin
						$error("done_res: expected %0d, got %0d", want.done_res, rsp_data.done_res);
						errors++;
					end
					if (rsp_data.erase_error !== want.erase_error) begin
						$error("erase_error: expected %0d, got %0d", want.erase_error,
							rsp_data.erase_error);
						errors++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				due_cycles.push_back(next_bus_cycle(cmd_data));
			pending <= due_cycles.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the NAND flash command sequencer bench: clock, reset, command and stall
// generation, verdict. Depends on ncs_pkg, ncs_stream_if, ncs_bus_cycle_check and the RTL.
`timescale 1ns / 1ps
module testbench;
	import ncs_pkg::*;

	localparam int         PAGE_SIZE = PAGE_BYTES_DEF;
	localparam int         NUM_WORDS = 950;
	localparam logic [2:0] OPC_TOP   = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   sent = 0;
	bit   calm = 1'b0;

	ncs_stream_if #(.payload_t(in_item_t))  cmd ();
	ncs_stream_if #(.payload_t(out_item_t)) rsp ();

	nand_flash_command_sequencer #(.PAGE_BYTES(PAGE_SIZE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp)
	);

	ncs_bus_cycle_check #(.PAGE_BYTES(PAGE_SIZE)) cycle_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.cmd_data(cmd.data),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data(rsp.data),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic in_item_t any_word(logic [2:0] opc);
		in_item_t w;
		w.opcode      = opc;
		w.page        = 16'($urandom);
		w.data_length = 10'($urandom_range(0, 512));
		w.write_data  = 8'($urandom);
		w.bus_data    = 8'($urandom);
		w.ready_req   = 1'($urandom);
		return w;
	endfunction

	task automatic send(input in_item_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data  <= w;
		do @(posedge clk); while (!cmd.ready);
		if (w.opcode <= OPC_STEP)
			sent++;
	endtask

	// hold off until every result word is back
	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic run_op();
		in_item_t   w;
		logic [2:0] pick;
		int         steps;
		int         budget;
		int         k;
		int         poll;
		calm = ($urandom_range(0, 5) == 0);
		pick = 3'($urandom_range(OPC_PROG, OPC_ID));
		w = any_word(pick);
		case ($urandom_range(0, 5))
			0:       w.data_length = 10'd0;
			1:       w.data_length = 10'(PAGE_SIZE);
			2:       w.data_length = 10'($urandom_range(PAGE_SIZE - 1, PAGE_SIZE + 1));
			3:       w.data_length = 10'($urandom_range(511, 512));
			default: w.data_length = 10'($urandom_range(0, PAGE_SIZE));
		endcase
		send(w);
		// cut some operations short with the next start
		budget = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : 1 << 30;
		if (budget > NUM_WORDS - sent)
			budget = NUM_WORDS - sent;
		case (pick)
			OPC_PROG: steps = PAGE_SIZE + 6;
			OPC_READ: steps = PAGE_SIZE + 5;
			OPC_ID:   steps = 4;
			default:  steps = 5;
		endcase
		for (k = 0; k < steps && k < budget; k++)
			send(any_word(OPC_STEP));
		if (pick == OPC_ERASE && k < budget) begin
			poll = 0;
			do begin
				w = any_word(OPC_STEP);
				w.ready_req = ($urandom_range(0, 2) == 0) || poll == 6;
				send(w);
				poll++;
			end while (!w.ready_req);
			send(any_word(OPC_STEP));
		end
		if ($urandom_range(0, 3) == 0)
			send(any_word(3'($urandom_range(OPC_STEP, OPC_TOP))));
		if ($urandom_range(0, 19) == 0)
			drain();
	endtask

	initial begin
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	initial begin
		in_item_t w;
		arst_n    <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray step and unused opcodes
		send(any_word(OPC_STEP));
		for (int k = 1; k <= 3; k++)
			send(any_word(3'(OPC_STEP + k)));

		// read id at the top page, both read bytes at the extremes
		w = any_word(OPC_ID);
		w.page        = 16'hFFFF;
		w.data_length = 10'd512;
		send(w);
		send(any_word(OPC_STEP));
		send(any_word(OPC_STEP));
		w = any_word(OPC_STEP);
		w.bus_data = 8'hFF;
		send(w);
		w.bus_data = 8'h00;
		send(w);

		// erase, ready at once, failing status
		w = any_word(OPC_ERASE);
		w.page = 16'h5AC3;
		send(w);
		for (int k = 0; k < 5; k++)
			send(any_word(OPC_STEP));
		w = any_word(OPC_STEP);
		w.ready_req = 1'b1;
		send(w);
		w = any_word(OPC_STEP);
		w.bus_data = 8'h01;
		send(w);

		// program with nothing supplied, abandoned by a read start
		w = any_word(OPC_PROG);
		w.page        = 16'h0000;
		w.data_length = 10'd0;
		send(w);
		for (int k = 0; k < 3; k++)
			send(any_word(OPC_STEP));
		w = any_word(OPC_READ);
		w.data_length = 10'd511;
		send(w);
		send(any_word(OPC_STEP));
		send(any_word(OPC_STEP));

		drain();

		while (sent < NUM_WORDS)
			run_op();

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ncs_pkg.sv
hw/rtl/ncs_stream_if.sv
hw/rtl/ncs_in_stage.sv
hw/rtl/ncs_seq.sv
hw/rtl/ncs_out_stage.sv
hw/rtl/nand_flash_command_sequencer.sv
dv/ncs_bus_cycle_check.sv
dv/testbench.sv
